// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AfterW = 2;
  localparam int unsigned CpW    = 21;
  localparam int unsigned InW    = 16;  // byte_value + bytes_after, padded to bytes
  localparam int unsigned OutW   = 24;  // code_point, padded to bytes

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_UNEXP = 2'd2
  } err_kind_t;

  // continuation bytes still expected after the current one
  typedef logic [1:0] pend_t;
  typedef logic [CpW-1:0] cp_t;

endpackage

// ===== sv/utf8_stream_decoder.sv =====
// UTF-8 byte stream to code point decoder. One byte is taken per slave word,
// with the count of bytes still following it in the string (saturated at 3,
// 0 on the string's last byte). ASCII bytes give a code point at once; lead
// bytes C0-DF, E0-EF and F0-F7 open two-, three- and four-byte sequences and
// the code point comes out with the last continuation byte. Overlong forms and
// surrogates pass unchecked. A lead byte without enough bytes left in the
// string reports a truncated sequence, a bad lead byte or a non-continuation
// byte inside a sequence reports an unexpected byte; after an error all bytes
// up to the string's last byte are dropped silently. Error words carry a zero
// code point. Throughput is one byte per clock while the master side takes
// words: the byte is registered, decoded against the sequence state in a single
// combinational pass and the result is registered. The byte moves on to the
// output register only when that is free or being drained; the input register
// takes a byte only then or when empty, so back-pressure stalls the slave side.
module utf8_stream_decoder
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  // slave side
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [InW-1:0]  s_tdata,   // [7:0] byte_value, [9:8] bytes_after, rest zero
  // master side
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OutW-1:0] m_tdata,   // [20:0] code_point, rest zero
  output logic [1:0]      m_tuser,   // [1:0] error_kind
  output logic            m_tlast    // string_end
);

  // input register
  logic              in_valid;
  logic [ByteW-1:0]  in_byte;
  logic [AfterW-1:0] in_after;

  // sequence state
  pend_t pending_count, pending_count_next;
  cp_t   accumulator, accumulator_next;
  logic  skipping, skipping_next;

  // result register
  cp_t       out_cp;
  err_kind_t out_err;
  logic      out_last;

  // decode outputs
  logic      res_valid;
  cp_t       res_cp;
  err_kind_t res_err;
  logic      in_last;
  pend_t     need;
  logic      lead_ok;
  cp_t       lead_acc;
  cp_t       acc_shift;
  pend_t     pend_dec;

  logic advance;

  // the decode stage moves on when the result slot is empty or being taken
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata[ByteW-1:0];
      in_after <= s_tdata[ByteW +: AfterW];
    end
  end

  assign in_last   = (in_after == '0);
  assign acc_shift = {accumulator[CpW-7:0], in_byte[5:0]};
  assign pend_dec  = pending_count - pend_t'(1);

  // lead byte classification
  always_comb begin
    lead_ok  = 1'b1;
    need     = pend_t'(0);
    lead_acc = '0;
    priority if (in_byte[7:5] == 3'b110) begin
      need     = pend_t'(1);
      lead_acc = cp_t'(in_byte[4:0]);
    end else if (in_byte[7:4] == 4'b1110) begin
      need     = pend_t'(2);
      lead_acc = cp_t'(in_byte[3:0]);
    end else if (in_byte[7:3] == 5'b11110) begin
      need     = pend_t'(3);
      lead_acc = cp_t'(in_byte[2:0]);
    end else begin
      lead_ok  = 1'b0;
    end
  end

  always_comb begin
    pending_count_next = pending_count;
    accumulator_next   = accumulator;
    skipping_next      = skipping;
    res_valid          = 1'b0;
    res_cp             = '0;
    res_err            = ERR_NONE;

    priority if (skipping) begin
      // drop bytes until the string's last byte
      pending_count_next = '0;
      accumulator_next   = '0;
      if (in_last) begin
        skipping_next = 1'b0;
      end
    end else if (pending_count != '0) begin
      if (in_byte[7:6] != 2'b10) begin
        res_valid          = 1'b1;
        res_err            = ERR_UNEXP;
        pending_count_next = '0;
        accumulator_next   = '0;
        skipping_next      = !in_last;
      end else if (pend_dec == '0) begin
        res_valid          = 1'b1;
        res_cp             = acc_shift;
        pending_count_next = '0;
        accumulator_next   = '0;
      end else if (in_last) begin
        // string ended inside a sequence
        res_valid          = 1'b1;
        res_err            = ERR_TRUNC;
        pending_count_next = '0;
        accumulator_next   = '0;
      end else begin
        pending_count_next = pend_dec;
        accumulator_next   = acc_shift;
      end
    end else if (!in_byte[7]) begin
      res_valid = 1'b1;
      res_cp    = cp_t'(in_byte[6:0]);
    end else if (!lead_ok) begin
      res_valid     = 1'b1;
      res_err       = ERR_UNEXP;
      skipping_next = !in_last;
    end else if (in_after < need) begin
      res_valid     = 1'b1;
      res_err       = ERR_TRUNC;
      skipping_next = !in_last;
    end else begin
      pending_count_next = need;
      accumulator_next   = lead_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= '0;
      accumulator   <= '0;
      skipping      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (advance) begin
        pending_count <= pending_count_next;
        accumulator   <= accumulator_next;
        skipping      <= skipping_next;
        m_tvalid      <= res_valid;
      end else if (m_tready) begin
        m_tvalid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_cp   <= res_cp;
      out_err  <= res_err;
      out_last <= in_last;
    end
  end

  assign m_tdata = {(OutW - CpW)'(0), out_cp};
  assign m_tuser = out_err;
  assign m_tlast = out_last;

  // error words never carry a code point
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_err != ERR_NONE) |-> (out_cp == '0))
    else $error("error word with nonzero code point");

  // no sequence is open while dropping bytes
  assert property (@(posedge clk) disable iff (rst)
    skipping |-> (pending_count == '0))
    else $error("sequence open while skipping");

  // accumulator is clear whenever no sequence is open
  assert property (@(posedge clk) disable iff (rst)
    (pending_count == '0) |-> (accumulator == '0))
    else $error("stale accumulator outside a sequence");

  // an error before the string's end starts dropping bytes
  assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && res_err != ERR_NONE && !in_last) |=> skipping)
    else $error("error mid-string did not start skipping");

  // a word accepted while the result slot is stalled must wait in the input register
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("stalled byte lost");

endmodule
